// File: hdl/rmr_pkg.sv
// Shared types and constants for the rational multiply-reduce unit.
package rmr_pkg;

  localparam int RMR_OPERAND_WIDTH = 16;
  localparam int RMR_RESULT_WIDTH  = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_D,
    ST_CHECK,
    ST_GCD,
    ST_SCALE,
    ST_DIV_N,
    ST_DIV_D,
    ST_SIGN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_num;
    logic mul_den;
    logic check;
    logic gcd_step;
    logic scale;
    logic div_num;
    logic div_den;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic both_zero;
    logic one_zero;
    logic gcd_equal;
    logic shift_zero;
    logic div_last;
  } stat_t;

endpackage

// File: hdl/rmr_alu.sv
// Shared subtract/compare unit used by the gcd loop and the divider.
module rmr_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic [WIDTH-1:0] diff,
  output logic             ge,
  output logic             zero
);
  logic [WIDTH:0] full;

  assign full = {1'b0, x} - {1'b0, y};
  assign diff = full[WIDTH-1:0];
  assign ge   = ~full[WIDTH];
  assign zero = (diff == '0);
endmodule

// File: hdl/rmr_ctrl.sv
// Sequencer for multiply, binary gcd, scale-back and the two divisions.
module rmr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  rmr_pkg::stat_t stat,
  output rmr_pkg::ctrl_t ctrl,
  output logic          busy
);
  import rmr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (stat.start) state_next = ST_MUL_N;
      ST_MUL_N: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.both_zero) state_next = ST_SIGN;
        else if (stat.one_zero) state_next = ST_DIV_N;
        else state_next = ST_GCD;
      end
      ST_GCD:   if (stat.gcd_equal) state_next = ST_SCALE;
      ST_SCALE: if (stat.shift_zero) state_next = ST_DIV_N;
      ST_DIV_N: if (stat.div_last) state_next = ST_DIV_D;
      ST_DIV_D: if (stat.div_last) state_next = ST_SIGN;
      ST_SIGN:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE:  ctrl.load     = 1'b1;
      ST_MUL_N: ctrl.mul_num  = 1'b1;
      ST_MUL_D: ctrl.mul_den  = 1'b1;
      ST_CHECK: ctrl.check    = 1'b1;
      ST_GCD:   ctrl.gcd_step = 1'b1;
      ST_SCALE: ctrl.scale    = 1'b1;
      ST_DIV_N: ctrl.div_num  = 1'b1;
      ST_DIV_D: ctrl.div_den  = 1'b1;
      ST_SIGN:  ctrl.finish   = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);
endmodule

// File: hdl/rational_multiply_reduce_unit.sv
// Top level: fraction multiply with gcd reduction on one shared subtractor.
//
//  beat      ports                                         handshake
//  ------    --------------------------------------------  ------------------
//  operands  lhs_numerator lhs_denominator rhs_numerator    start & !busy
//            rhs_denominator
//  result    result_numerator result_denominator            done (1-cycle pulse)
//
// Accepted beat to next accepted beat, an item runs through both multiplies, the check,
// the gcd steps (swaps and the closing compare included), the k scale steps, the
// divisions of numerator and denominator by the gcd and the sign step.
// A zero product skips gcd and scale; both zero skips the divides too.
// The gcd loop and the restoring divider both run on the single subtract/compare unit,
// one step a cycle.
// Reset (synchronous) returns the sequencer to idle and clears done.
// busy stays high until the result beat; results cannot be stalled and show
// for exactly one cycle.
module rational_multiply_reduce_unit #(
  parameter int OPERAND_WIDTH = rmr_pkg::RMR_OPERAND_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [OPERAND_WIDTH-1:0]      lhs_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]      lhs_denominator,
  input  logic signed [OPERAND_WIDTH-1:0]      rhs_numerator,
  input  logic signed [OPERAND_WIDTH-1:0]      rhs_denominator,
  output logic                                 done,
  output logic signed [rmr_pkg::RMR_RESULT_WIDTH-1:0] result_numerator,
  output logic signed [rmr_pkg::RMR_RESULT_WIDTH-1:0] result_denominator
);
  import rmr_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);
  localparam int XW = (PW > RMR_RESULT_WIDTH) ? PW : RMR_RESULT_WIDTH;

  ctrl_t ctrl;
  stat_t stat;

  logic [W-1:0]  mag_ln, mag_ld, mag_rn, mag_rd;
  logic          sign_num, sign_den;
  logic [PW-1:0] pn, pd, a, b, g, quo, rem;
  logic [CW-1:0] k, cnt;
  logic          done_q;
  logic [RMR_RESULT_WIDTH-1:0] res_num, res_den;

  // operand magnitudes
  logic [W-1:0] ln_u, ld_u, rn_u, rd_u;
  logic [W-1:0] ln_mag, ld_mag, rn_mag, rd_mag;
  assign ln_u = lhs_numerator;
  assign ld_u = lhs_denominator;
  assign rn_u = rhs_numerator;
  assign rd_u = rhs_denominator;
  assign ln_mag = ln_u[W-1] ? (~ln_u + 1'b1) : ln_u;
  assign ld_mag = ld_u[W-1] ? (~ld_u + 1'b1) : ld_u;
  assign rn_mag = rn_u[W-1] ? (~rn_u + 1'b1) : rn_u;
  assign rd_mag = rd_u[W-1] ? (~rd_u + 1'b1) : rd_u;

  // shared multiplier, used once for each product
  logic [W-1:0]  mul_x, mul_y;
  logic [PW-1:0] prod;
  assign mul_x = ctrl.mul_num ? mag_ln : mag_ld;
  assign mul_y = ctrl.mul_num ? mag_rn : mag_rd;
  assign prod  = PW'(mul_x) * PW'(mul_y);

  // shared subtract/compare
  logic [PW:0]   alu_x, alu_y, alu_diff, rem_shift;
  logic          alu_ge, alu_zero;
  assign rem_shift = {rem, quo[PW-1]};
  assign alu_x = ctrl.gcd_step ? {1'b0, a} : rem_shift;
  assign alu_y = ctrl.gcd_step ? {1'b0, b} : {1'b0, g};

  rmr_alu #(.WIDTH(PW + 1)) u_alu (
    .x    (alu_x),
    .y    (alu_y),
    .diff (alu_diff),
    .ge   (alu_ge),
    .zero (alu_zero)
  );

  logic [PW-1:0] quo_next, rem_next;
  assign quo_next = {quo[PW-2:0], alu_ge};
  assign rem_next = alu_ge ? alu_diff[PW-1:0] : rem_shift[PW-1:0];

  assign stat.start      = start;
  assign stat.both_zero  = (pn == '0) && (pd == '0);
  assign stat.one_zero   = (pn == '0) || (pd == '0);
  assign stat.gcd_equal  = alu_zero;
  assign stat.shift_zero = (k == '0);
  assign stat.div_last   = (cnt == CW'(PW - 1));

  rmr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  // sign application on the way out
  logic [XW-1:0] num_ext, den_ext, num_out, den_out;
  assign num_ext = XW'(pn);
  assign den_ext = XW'(pd);
  assign num_out = (sign_num && pn != '0) ? (XW'(0) - num_ext) : num_ext;
  assign den_out = (sign_den && pd != '0) ? (XW'(0) - den_ext) : den_ext;

  always_ff @(posedge clk) begin
    if (ctrl.load && start) begin
      mag_ln   <= ln_mag;
      mag_ld   <= ld_mag;
      mag_rn   <= rn_mag;
      mag_rd   <= rd_mag;
      sign_num <= ln_u[W-1] ^ rn_u[W-1];
      sign_den <= ld_u[W-1] ^ rd_u[W-1];
    end
    if (ctrl.mul_num) pn <= prod;
    if (ctrl.mul_den) pd <= prod;
    if (ctrl.check) begin
      a   <= pn;
      b   <= pd;
      k   <= '0;
      g   <= pn | pd;      // gcd when one product is zero
      quo <= pn;
      rem <= '0;
      cnt <= '0;
    end
    if (ctrl.gcd_step) begin
      if (alu_zero) begin
        g <= a;
      end else if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (alu_ge) begin
        a <= alu_diff[PW-1:0];
      end else begin
        a <= b;              // swap so the next step subtracts the smaller
        b <= a;
      end
    end
    if (ctrl.scale && k != '0) begin
      g <= g << 1;
      k <= k - 1'b1;
    end
    if (ctrl.div_num || ctrl.div_den) begin
      if (stat.div_last) begin
        cnt <= '0;
        rem <= '0;
        if (ctrl.div_num) begin
          pn  <= quo_next;
          quo <= pd;
        end else begin
          pd  <= quo_next;
          quo <= quo_next;
        end
      end else begin
        cnt <= cnt + 1'b1;
        quo <= quo_next;
        rem <= rem_next;
      end
    end
    if (ctrl.finish) begin
      res_num <= num_out[RMR_RESULT_WIDTH-1:0];
      res_den <= den_out[RMR_RESULT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.finish;
    end
  end

  assign done               = done_q;
  assign result_numerator   = res_num;
  assign result_denominator = res_den;
endmodule

// File: hdl/rmr_checker.sv
// Port-level checks for the rational multiply-reduce unit, bound to the top level.
module rmr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat longer than one cycle");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("reset did not idle the unit");
endmodule

bind rational_multiply_reduce_unit rmr_checker u_rmr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// File: tb/tb_rational_multiply_reduce_unit.sv
// Testbench for the rational multiply-reduce unit: directed and random fractions, scoreboarded.
module tb_rational_multiply_reduce_unit;
  import rmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = RMR_OPERAND_WIDTH;
  localparam int R = RMR_RESULT_WIDTH;
  localparam int RANDOM_BEATS = 580;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [W-1:0] operand_t;
  typedef logic signed [R-1:0] result_t;

  typedef struct packed {
    result_t numerator;
    result_t denominator;
  } fraction_t;

  class fraction_scoreboard;
    fraction_t   pending_fractions[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned reduced_items = 0;
    int unsigned zero_items = 0;

    // Products fit easily in 64 bits at this width; Euclid on magnitudes.
    function fraction_t reduced_product(operand_t ln, operand_t ld, operand_t rn, operand_t rd);
      longint    a_n, a_d, b_n, b_d, pn, pd, x, y, r;
      bit        neg_n, neg_d;
      fraction_t f;
      a_n = longint'(ln);
      a_d = longint'(ld);
      b_n = longint'(rn);
      b_d = longint'(rd);
      pn = (a_n < 0 ? -a_n : a_n) * (b_n < 0 ? -b_n : b_n);
      pd = (a_d < 0 ? -a_d : a_d) * (b_d < 0 ? -b_d : b_d);
      neg_n = ((a_n < 0) != (b_n < 0)) && (pn != 0);
      neg_d = ((a_d < 0) != (b_d < 0)) && (pd != 0);
      if (pn == 0 || pd == 0) zero_items++;
      x = pn;
      y = pd;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      // zero gcd only when both products are zero: leave 0/0 alone
      if (x != 0) begin
        pn = pn / x;
        pd = pd / x;
        if (x > 1) reduced_items++;
      end
      f.numerator   = result_t'(neg_n ? -pn : pn);
      f.denominator = result_t'(neg_d ? -pd : pd);
      return f;
    endfunction

    function void note_operands(operand_t ln, operand_t ld, operand_t rn, operand_t rd);
      pending_fractions.push_back(reduced_product(ln, ld, rn, rd));
    endfunction

    function void check_result(result_t num, result_t den);
      fraction_t want;
      results_seen++;
      if (pending_fractions.size() == 0) begin
        $display("%0t: unexpected result beat %0d/%0d", $time, num, den);
        mismatches++;
        return;
      end
      want = pending_fractions.pop_front();
      if (num !== want.numerator) begin
        $display("%0t: result_numerator expected %0d actual %0d",
                 $time, want.numerator, num);
        mismatches++;
      end
      if (den !== want.denominator) begin
        $display("%0t: result_denominator expected %0d actual %0d",
                 $time, want.denominator, den);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  operand_t lhs_numerator = '0;
  operand_t lhs_denominator = '0;
  operand_t rhs_numerator = '0;
  operand_t rhs_denominator = '0;
  logic     busy;
  logic     done;
  result_t  result_numerator;
  result_t  result_denominator;

  fraction_scoreboard sb = new();
  int unsigned        beats_sent = 0;
  bit                 quiet_stretch = 1'b0;

  rational_multiply_reduce_unit #(.OPERAND_WIDTH(W)) DUT (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .lhs_numerator     (lhs_numerator),
    .lhs_denominator   (lhs_denominator),
    .rhs_numerator     (rhs_numerator),
    .rhs_denominator   (rhs_denominator),
    .done              (done),
    .result_numerator  (result_numerator),
    .result_denominator(result_denominator)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result_numerator, result_denominator);
  end

  task automatic send_operands(input operand_t ln, input operand_t ld,
                               input operand_t rn, input operand_t rd);
    start           <= 1'b1;
    lhs_numerator   <= ln;
    lhs_denominator <= ld;
    rhs_numerator   <= rn;
    rhs_denominator <= rd;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_operands(ln, ld, rn, rd);
    beats_sent++;
  endtask

  // start low with junk on the operand ports
  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      lhs_numerator   <= operand_t'($urandom);
      lhs_denominator <= operand_t'($urandom);
      rhs_numerator   <= operand_t'($urandom);
      rhs_denominator <= operand_t'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic maybe_idle();
    if (!quiet_stretch && $urandom_range(0, 99) < 23) begin
      // long gaps land on every phase of the gcd and divide sequence
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 200));
      else idle_gap($urandom_range(1, 6));
    end
  endtask

  function automatic operand_t edge_operand();
    case ($urandom_range(0, 5))
      0:       return operand_t'(-32768);
      1:       return operand_t'(32767);
      2:       return operand_t'(-1);
      3:       return operand_t'(1);
      4:       return operand_t'(0);
      default: return operand_t'(-32767);
    endcase
  endfunction

  function automatic operand_t small_operand();
    return operand_t'(int'($urandom_range(0, 32)) - 16);
  endfunction

  // shared factor k, times a cofactor in [-181, 181]
  function automatic operand_t scaled_operand(int k);
    return operand_t'(k * (int'($urandom_range(0, 362)) - 181));
  endfunction

  operand_t directed_ops [0:17][0:3] = '{
    '{1, 2, 3, 4},
    '{0, 5, 7, 0},
    '{0, 0, 0, 0},
    '{0, 3, 5, -7},
    '{5, 0, -3, 9},
    '{-5, 0, -5, 0},
    '{6, 4, 0, -3},
    '{-32768, -32768, -32768, -32768},
    '{32767, -32768, 32767, 32767},
    '{-32768, 32767, 32767, -32768},
    '{32767, 32767, -32768, -32768},
    '{-32768, 1, 32767, 1},
    '{7, 3, 6, 1},
    '{-1, 1, 1, -1},
    '{12, -18, -15, 10},
    '{1, 1, 1, 1},
    '{-32768, -1, -1, -32768},
    '{21845, -10922, -32767, 32766}
  };

  initial begin
    operand_t ln, ld, rn, rd;
    int       k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_ops[i]) begin
      send_operands(directed_ops[i][0], directed_ops[i][1],
                    directed_ops[i][2], directed_ops[i][3]);
      maybe_idle();
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      quiet_stretch = (i >= 200 && i < 350);
      case ($urandom_range(0, 9))
        0, 1: begin
          ln = small_operand();
          ld = small_operand();
          rn = small_operand();
          rd = small_operand();
        end
        2: begin
          ln = edge_operand();
          ld = edge_operand();
          rn = edge_operand();
          rd = edge_operand();
        end
        3, 4: begin
          k  = $urandom_range(2, 181);
          ln = scaled_operand(k);
          ld = scaled_operand($urandom_range(1, 181));
          rn = scaled_operand($urandom_range(1, 181));
          rd = scaled_operand(k);
        end
        5: begin
          // integer multiplier
          ln = operand_t'($urandom);
          ld = operand_t'($urandom);
          rn = operand_t'($urandom);
          rd = operand_t'(1);
        end
        default: begin
          ln = operand_t'($urandom);
          ld = operand_t'($urandom);
          rn = operand_t'($urandom);
          rd = operand_t'($urandom);
        end
      endcase
      send_operands(ln, ld, rn, rd);
      maybe_idle();
    end
    start <= 1'b0;

    while (sb.pending_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d operand beats, %0d result beats, %0d mismatches",
             beats_sent, sb.results_seen, sb.mismatches);
    $display("run: %0d reduced by a gcd above one, %0d with a zero product",
             sb.reduced_items, sb.zero_items);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
